[src/best_fit_block_allocator_defines.svh]
// Assertion macros shared by the best-fit allocator RTL.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define BFA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bfa_pkg.sv]
// Package: shared types and codes of the best-fit block allocator.
`timescale 1ns / 1ps
package bfa_pkg;

  // Operation codes on the operation port
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_ALLOC  = 2'd2,
    ST_NOFIT  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Control from the sequencer to the best-candidate tracker
  typedef struct packed {
    logic clear;   // start of a new request
    logic sample;  // table read data is valid this cycle
  } scan_ctl_t;

endpackage

[src/bfa_table.sv]
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module bfa_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bfa_scan.sv]
// Best-candidate tracker: keeps the free block with the least leftover.
`timescale 1ns / 1ps
module bfa_scan
  import bfa_pkg::*;
#(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_ctl_t            ctl,
  input  logic [IDX_W-1:0]     idx,
  input  logic [SIZE_BITS-1:0] req,
  input  logic                 rd_taken,
  input  logic [SIZE_BITS-1:0] rd_size,
  output logic                 found,
  output logic [IDX_W-1:0]     best_idx,
  output logic [SIZE_BITS-1:0] best_size,
  output logic [SIZE_BITS-1:0] best_left
);

  logic                 fits;
  logic                 better;
  logic [SIZE_BITS-1:0] left;

  // strict less-than keeps the lowest block number on a tie
  always_comb begin
    fits   = !rd_taken && (rd_size >= req);
    left   = rd_size - req;
    better = fits && (!found || (left < best_left));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.sample && better) begin
      found <= 1'b1;
    end
  end

  // candidate payload
  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.sample && better) begin
      best_idx  <= idx;
      best_size <= rd_size;
      best_left <= left;
    end
  end

endmodule

[src/best_fit_block_allocator.sv]
// Top level: best-fit block allocator with sequencer and result register.
//
// Usage: raise start with operation and its operand; the word is taken at a
// rising edge where start is high and busy is low. Every accepted word gives
// exactly one result word on status/block_number/leftover, marked by done
// for one cycle. The receiver cannot stall; a result is gone after that cycle.
// Load (operation 0): unless the table is full, the size is written at the
//   next free table entry in the accept cycle; done follows in the next
//   cycle. busy stays low, so a load can be issued every cycle.
// Allocate (operation 1): the table is read one entry per cycle over the
//   loaded blocks (single read port), then a drain state covers the read
//   latency and a finish state writes back the taken flag when a block
//   fits. When no block is loaded, busy stays low and a no-fit result is
//   given without a scan.
// Reset (rst, synchronous): the fill count goes to zero, so the table is
//   empty at once; no clearing pass is run. Each entry holds its size and
//   a taken flag, written free on load.
`timescale 1ns / 1ps
`include "best_fit_block_allocator_defines.svh"
module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [15:0] block_size,
  input  logic [15:0] request_size,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  block_number,
  output logic [15:0] leftover
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W = SIZE_BITS + 1;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     d_idx;
  logic                 dv;
  logic [SIZE_BITS-1:0] req;

  logic                 accept;
  logic                 full;
  logic                 last_rd;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [ENT_W-1:0]     mem_rdata;
  scan_ctl_t            scan_ctl;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] best_left;
  logic                 res_valid;
  status_t              res_status;
  logic [4:0]           res_num;
  logic [15:0]          res_left;
  status_t              status_q;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count == CNT_W'(MAX_BLOCKS));
  assign last_rd = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);

  bfa_table #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W),
    .WIDTH (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  bfa_scan #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .idx       (d_idx),
    .req       (req),
    .rd_taken  (mem_rdata[SIZE_BITS]),
    .rd_size   (mem_rdata[SIZE_BITS-1:0]),
    .found     (found),
    .best_idx  (best_idx),
    .best_size (best_size),
    .best_left (best_left)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (operation == OP_ALLOC) && (count != '0)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_rd) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = count[IDX_W-1:0];
    mem_wdata      = {1'b0, SIZE_BITS'(block_size)};
    mem_re         = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.sample = dv;
    res_valid      = 1'b0;
    res_status     = ST_LOADED;
    res_num        = '0;
    res_left       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_LOAD) begin
            res_valid = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              res_num = 5'(count + CNT_W'(1));
            end
          end else begin
            scan_ctl.clear = 1'b1;
            if (count == '0) begin
              res_valid  = 1'b1;
              res_status = ST_NOFIT;
            end
          end
        end
      end
      S_SCAN: begin
        mem_re = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (found) begin
          // write back the winner marked taken
          mem_we     = 1'b1;
          mem_waddr  = best_idx;
          mem_wdata  = {1'b1, best_size};
          res_status = ST_ALLOC;
          res_num    = 5'(CNT_W'(best_idx) + CNT_W'(1));
          res_left   = 16'(best_left);
        end else begin
          res_status = ST_NOFIT;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= mem_re;
      done  <= res_valid;
      if (state == S_IDLE && mem_we) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // read address walk and request capture
  always_ff @(posedge clk) begin
    d_idx <= rd_idx;
    if (state == S_IDLE) begin
      rd_idx <= '0;
    end else if (mem_re) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    if (accept) begin
      req <= SIZE_BITS'(request_size);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (res_valid) begin
      status_q     <= res_status;
      block_number <= res_num;
      leftover     <= res_left;
    end
  end

  assign status = status_q;

  `BFA_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_BLOCKS), "fill count past table size")
  `BFA_ASSERT_IMP(a_alloc_num, clk, rst, done && (status == ST_ALLOC), block_number != 5'd0 || MAX_BLOCKS > 30, "allocation reported block zero")
  `BFA_ASSERT_IMP(a_nofit_zero, clk, rst, done && (status == ST_NOFIT), block_number == 5'd0 && leftover == 16'd0, "no-fit result carries data")
  `BFA_ASSERT_NXT(a_alloc_busy, clk, rst, accept && (operation == OP_ALLOC) && (count != '0), busy && !done, "scan did not start")
  `BFA_ASSERT_NXT(a_finish_done, clk, rst, state == S_FINISH, done && !busy, "allocation ended without result")

endmodule
